// ----- rtl/nfarx_pkg.sv -----
// shared types and constants for the nfa regex prefix matcher
`default_nettype none
package nfarx_pkg;

    localparam int NUM_STATES_DEF = 32;
    localparam int POS_BITS_DEF   = 16;
    localparam int IDX_BITS       = 5;
    localparam int CHAR_BITS      = 8;
    localparam int LEN_BITS       = 16;

    // input word kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [IDX_BITS-1:0]  entry_index;
        logic [CHAR_BITS-1:0] entry_char;
        logic                 entry_is_eps;
        logic [IDX_BITS-1:0]  entry_next_a;
        logic [IDX_BITS-1:0]  entry_next_b;
        logic [CHAR_BITS-1:0] text_char;
    } t_in_word;

    typedef struct packed {
        logic                matched;
        logic [LEN_BITS-1:0] match_length;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_WRITE = 3'd1,
        OP_SEED  = 3'd2,
        OP_CHAR  = 3'd3,
        OP_CLOSE = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [IDX_BITS-1:0]  idx;
        logic [CHAR_BITS-1:0] ch;
        logic                 eps;
        logic [IDX_BITS-1:0]  next_a;
        logic [IDX_BITS-1:0]  next_b;
        logic [IDX_BITS-1:0]  start;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/nfa_regex_prefix_matcher.sv -----
// a table load is written as it is taken; start and character words pass the step state,
// then closure rounds (1 to NUM_STATES), one per cycle, until the active set stops growing;
// on a match the done state places the result; an end word before the decision goes to done
// words are taken one at a time: the next is not taken until the epsilon closure rounds across
// the chain of state cells end and any result is placed, so a waiting result holds the input
// reset: clears the active set, control and output valid; table entries stay undefined
`default_nettype none
module nfa_regex_prefix_matcher #(
    parameter int NUM_STATES = nfarx_pkg::NUM_STATES_DEF,
    parameter int POS_BITS   = nfarx_pkg::POS_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  nfarx_pkg::t_in_word    i_data,
    output logic                         o_valid,
    input  wire                          i_ready,
    output nfarx_pkg::t_out_word         o_data,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [nfarx_pkg::IDX_BITS-1:0] i_cfg_data
);
    import nfarx_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_STEP  = 4'b0010,
        S_CLOSE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state;
    logic [IDX_BITS-1:0]  r_start;
    logic [1:0]           r_kind;
    logic [CHAR_BITS-1:0] r_char;
    logic [POS_BITS-1:0]  r_pos;
    logic                 r_dec;
    logic                 r_hit;
    t_out_word            r_res;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_word            r_out;

    t_cell_ctl             w_ctl;
    logic [NUM_STATES-1:0] w_vec [NUM_STATES+1];
    logic                  w_hit [NUM_STATES+1];
    logic [NUM_STATES-1:0] w_fin;
    logic [NUM_STATES-1:0] w_active;
    logic                  w_changed;
    logic                  w_accept;
    logic [31:0]           w_pos32;
    logic [LEN_BITS-1:0]   w_len;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid & o_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    assign w_pos32 = 32'(r_pos);
    assign w_len   = (w_pos32 > 32'h0000_FFFF) ? {LEN_BITS{1'b1}} : w_pos32[LEN_BITS-1:0];

    // cell control word
    always_comb begin
        w_ctl.op     = OP_HOLD;
        w_ctl.idx    = i_data.entry_index;
        w_ctl.ch     = i_data.entry_char;
        w_ctl.eps    = i_data.entry_is_eps;
        w_ctl.next_a = i_data.entry_next_a;
        w_ctl.next_b = i_data.entry_next_b;
        w_ctl.start  = r_start;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_data.kind == KIND_LOAD)) begin
                    w_ctl.op = OP_WRITE;
                end
            end
            S_STEP: begin
                w_ctl.op = (r_kind == KIND_START) ? OP_SEED : OP_CHAR;
                w_ctl.ch = r_char;
            end
            S_CLOSE: w_ctl.op = OP_CLOSE;
            S_DONE:  w_ctl.op = OP_HOLD;
            default: w_ctl.op = OP_HOLD;
        endcase
    end

    // output valid: cleared when taken, set when a result is placed
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
            n_out_valid = 1'b1;
        end
    end

    assign w_vec[0] = '0;
    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
        nfarx_cell #(
            .NUM_STATES (NUM_STATES),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_vec      (w_vec[g]),
            .i_hit      (w_hit[g]),
            .i_act_next (w_fin[g]),
            .o_vec      (w_vec[g+1]),
            .o_hit      (w_hit[g+1]),
            .o_act      (w_active[g])
        );
    end

    assign w_fin     = w_vec[NUM_STATES];
    assign w_changed = |(w_fin & ~w_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= '0;
            r_kind      <= KIND_LOAD;
            r_pos       <= '0;
            r_dec       <= 1'b1;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_data.kind)
                            KIND_START: begin
                                r_kind  <= KIND_START;
                                r_dec   <= 1'b0;
                                r_pos   <= '0;
                                r_state <= S_STEP;
                            end
                            KIND_CHAR: begin
                                if (!r_dec) begin
                                    r_kind  <= KIND_CHAR;
                                    r_state <= S_STEP;
                                    if (r_pos != POS_MAX) begin
                                        r_pos <= r_pos + 1'b1;
                                    end
                                end
                            end
                            KIND_END: begin
                                if (!r_dec) begin
                                    r_dec   <= 1'b1;
                                    r_state <= S_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_STEP: begin
                    // seeding enters start without counting as a return to it
                    r_hit   <= (r_kind == KIND_CHAR) ? w_hit[NUM_STATES] : 1'b0;
                    r_state <= S_CLOSE;
                end
                S_CLOSE: begin
                    r_hit <= r_hit | w_hit[NUM_STATES];
                    if (!w_changed) begin
                        if (r_hit || w_hit[NUM_STATES]) begin
                            r_dec   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result and word payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_accept && (i_data.kind == KIND_CHAR)) begin
            r_char <= i_data.text_char;
        end
        if ((r_state == S_IDLE) && w_accept && (i_data.kind == KIND_END)) begin
            r_res.matched      <= 1'b0;
            r_res.match_length <= '0;
        end else if ((r_state == S_CLOSE) && !w_changed) begin
            r_res.matched      <= 1'b1;
            r_res.match_length <= w_len;
        end
        if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
            r_out <= r_res;
        end
    end

`ifndef SYNTHESIS
    // closure rounds only ever add states
    a_close_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE) |=> ((w_active & $past(w_active)) == $past(w_active)))
        else $error("active set lost a state during closure");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.matched) |-> (o_data.match_length == '0))
        else $error("no-match word carries a length");

    a_word_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> r_dec)
        else $error("result word without a decision");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE) |-> (!o_ready && (w_ctl.op == OP_CLOSE)))
        else $error("input taken during closure");
`endif

endmodule
`default_nettype wire

// ----- rtl/nfarx_cell.sv -----
// one nfa state: its table entry, its active bit and its slice of the successor chain
`default_nettype none
module nfarx_cell #(
    parameter int NUM_STATES = nfarx_pkg::NUM_STATES_DEF,
    parameter int CELL_IDX   = 0
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  nfarx_pkg::t_cell_ctl i_ctl,
    input  wire  [NUM_STATES-1:0]      i_vec,
    input  wire                        i_hit,
    input  wire                        i_act_next,
    output logic [NUM_STATES-1:0]      o_vec,
    output logic                       o_hit,
    output logic                       o_act
);
    import nfarx_pkg::*;

    logic                 r_act;
    logic                 r_eps;
    logic [CHAR_BITS-1:0] r_ch;
    logic [IDX_BITS-1:0]  r_na;
    logic [IDX_BITS-1:0]  r_nb;

    logic                  w_fire_a;
    logic                  w_fire_b;
    logic                  w_start_ok;
    logic [NUM_STATES-1:0] w_contrib;

    assign w_start_ok = (32'(i_ctl.start) < NUM_STATES);

    always_comb begin
        w_fire_a = 1'b0;
        w_fire_b = 1'b0;
        if (i_ctl.op == OP_CLOSE) begin
            w_fire_a = r_act & r_eps;
            w_fire_b = r_act & r_eps;
        end else if (i_ctl.op == OP_CHAR) begin
            w_fire_a = r_act & ~r_eps & (r_ch == i_ctl.ch);
        end
    end

    // successors at or beyond the state count fall off the vector
    always_comb begin
        for (int j = 0; j < NUM_STATES; j++) begin
            w_contrib[j] = (w_fire_a && (32'(r_na) == j)) || (w_fire_b && (32'(r_nb) == j));
        end
    end

    assign o_vec = i_vec | w_contrib;
    assign o_hit = i_hit | (w_start_ok & ((w_fire_a & (r_na == i_ctl.start)) |
                                          (w_fire_b & (r_nb == i_ctl.start))));
    assign o_act = r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            unique case (i_ctl.op) inside
                OP_SEED:  r_act <= (32'(i_ctl.start) == CELL_IDX);
                OP_CHAR:  r_act <= i_act_next;
                OP_CLOSE: r_act <= r_act | i_act_next;
                OP_HOLD, OP_WRITE: r_act <= r_act;
                default:  r_act <= r_act;
            endcase
        end
    end

    // table entry, undefined until written
    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == OP_WRITE) && (32'(i_ctl.idx) == CELL_IDX)) begin
            r_eps <= i_ctl.eps;
            r_ch  <= i_ctl.ch;
            r_na  <= i_ctl.next_a;
            r_nb  <= i_ctl.next_b;
        end
    end

endmodule
`default_nettype wire

// ----- tb/nfa_regex_prefix_matcher_chk.sv -----
// checker for the nfa regex prefix matcher: bit-set prediction and result compare
module nfa_regex_prefix_matcher_chk (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_word_valid,
    input  wire                            i_word_ready,
    input  nfarx_pkg::t_in_word            i_word,
    input  wire                            i_res_valid,
    input  wire                            i_res_ready,
    input  nfarx_pkg::t_out_word           i_res,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire  [nfarx_pkg::IDX_BITS-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_live_words,
    output int                             o_results,
    output int                             o_matches
);
    localparam int N  = nfarx_pkg::NUM_STATES_DEF;
    localparam int QD = 8;

    logic [nfarx_pkg::CHAR_BITS-1:0] tab_char [N];
    bit                              tab_eps  [N];
    logic [nfarx_pkg::IDX_BITS-1:0]  tab_na   [N];
    logic [nfarx_pkg::IDX_BITS-1:0]  tab_nb   [N];

    bit [N-1:0]                      live_set;
    logic [nfarx_pkg::LEN_BITS-1:0]  text_pos;
    bit                              decided;
    logic [nfarx_pkg::IDX_BITS-1:0]  start_st;

    nfarx_pkg::t_out_word            outcome_buf [QD];
    int                              q_rd;
    int                              q_wr;
    int                              q_cnt;
    nfarx_pkg::t_out_word            want;

    // adds a state to the set; tells whether it is the start state
    function automatic bit mark_state(inout bit [N-1:0] states,
                                      input logic [nfarx_pkg::IDX_BITS-1:0] s,
                                      inout bit grew);
        if (!states[s]) begin
            states[s] = 1'b1;
            grew = 1'b1;
        end
        return s == start_st;
    endfunction

    // epsilon closure in place; true if an epsilon edge enters the start state
    function automatic bit close_over_eps(inout bit [N-1:0] states);
        bit hit;
        bit grew;
        hit  = 1'b0;
        grew = 1'b1;
        while (grew) begin
            grew = 1'b0;
            for (int i = 0; i < N; i++) begin
                if (states[i] && tab_eps[i]) begin
                    if (mark_state(states, tab_na[i], grew))
                        hit = 1'b1;
                    if (mark_state(states, tab_nb[i], grew))
                        hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic void expect_outcome(bit m, logic [nfarx_pkg::LEN_BITS-1:0] len);
        nfarx_pkg::t_out_word r;
        r.matched      = m;
        r.match_length = m ? len : '0;
        decided = 1'b1;
        if (q_cnt == QD) begin
            $display("%0t: expected result buffer overflow", $time);
            o_fail_count++;
        end else begin
            outcome_buf[q_wr] = r;
            q_wr = (q_wr + 1) % QD;
            q_cnt++;
        end
    endfunction

    function automatic void advance_matcher(nfarx_pkg::t_in_word w);
        bit [N-1:0] nxt;
        bit hit;
        bit grew;
        hit  = 1'b0;
        grew = 1'b0;
        nxt  = '0;
        case (w.kind)
            nfarx_pkg::KIND_LOAD: begin
                o_live_words++;
                tab_char[w.entry_index] = w.entry_char;
                tab_eps[w.entry_index]  = w.entry_is_eps;
                tab_na[w.entry_index]   = w.entry_next_a;
                tab_nb[w.entry_index]   = w.entry_next_b;
            end
            nfarx_pkg::KIND_START: begin
                o_live_words++;
                live_set = '0;
                text_pos = '0;
                decided  = 1'b0;
                void'(mark_state(live_set, start_st, grew));
                if (close_over_eps(live_set))
                    expect_outcome(1'b1, '0);
            end
            nfarx_pkg::KIND_CHAR: begin
                if (!decided) begin
                    o_live_words++;
                    for (int i = 0; i < N; i++) begin
                        if (live_set[i] && !tab_eps[i] && tab_char[i] == w.text_char) begin
                            if (mark_state(nxt, tab_na[i], grew))
                                hit = 1'b1;
                        end
                    end
                    // position sticks at all ones
                    if (text_pos != '1)
                        text_pos++;
                    if (close_over_eps(nxt))
                        hit = 1'b1;
                    live_set = nxt;
                    if (hit)
                        expect_outcome(1'b1, text_pos);
                end
            end
            nfarx_pkg::KIND_END: begin
                if (!decided) begin
                    o_live_words++;
                    expect_outcome(1'b0, '0);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_set     = '0;
            text_pos     = '0;
            decided      = 1'b1;
            start_st     = '0;
            q_rd         = 0;
            q_wr         = 0;
            q_cnt        = 0;
            o_fail_count = 0;
            o_live_words = 0;
            o_results    = 0;
            o_matches    = 0;
            for (int i = 0; i < N; i++) begin
                tab_char[i] = '0;
                tab_eps[i]  = 1'b0;
                tab_na[i]   = '0;
                tab_nb[i]   = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                start_st = i_cfg_data;
            // compare first: a result never belongs to the word taken on the same edge
            if (i_res_valid && i_res_ready) begin
                o_results++;
                if (q_cnt == 0) begin
                    $display("%0t: result word with none expected: matched %0d length %0d",
                             $time, i_res.matched, i_res.match_length);
                    o_fail_count++;
                end else begin
                    want = outcome_buf[q_rd];
                    q_rd = (q_rd + 1) % QD;
                    q_cnt--;
                    if (i_res.matched !== want.matched) begin
                        $display("%0t: matched expected %0d, got %0d",
                                 $time, want.matched, i_res.matched);
                        o_fail_count++;
                    end
                    if (i_res.match_length !== want.match_length) begin
                        $display("%0t: match_length expected %0d, got %0d",
                                 $time, want.match_length, i_res.match_length);
                        o_fail_count++;
                    end
                    if (want.matched)
                        o_matches++;
                end
            end
            if (i_word_valid && i_word_ready)
                advance_matcher(i_word);
        end
        o_pending = q_cnt;
    end

endmodule

// ----- tb/nfa_regex_prefix_matcher_tb.sv -----
// testbench top for the nfa regex prefix matcher: stimulus, idling and verdict
module nfa_regex_prefix_matcher_tb;
    localparam int     N_STATES    = nfarx_pkg::NUM_STATES_DEF;
    localparam int     SETTLE      = N_STATES + 8;
    localparam int     WORD_TARGET = 1900;
    localparam int     N_PHASES    = 10;
    localparam int     MAX_MEMBERS = 10;
    localparam longint CYCLE_LIMIT = 10_000_000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           o_ready;
    nfarx_pkg::t_in_word            i_data      = '0;
    logic                           o_valid;
    logic                           i_ready     = 1'b1;
    nfarx_pkg::t_out_word           o_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [nfarx_pkg::IDX_BITS-1:0] i_cfg_data  = '0;

    bit     idle_on = 1'b0;
    int     fail_count;
    int     pending;
    int     live_words;
    int     results;
    int     match_count;
    int     texts_sent = 0;
    int     cfg_writes = 0;
    int     words_sent = 0;
    longint cycles     = 0;

    logic [nfarx_pkg::IDX_BITS-1:0]  members [MAX_MEMBERS];
    int                              n_members = 0;
    logic [nfarx_pkg::CHAR_BITS-1:0] alphabet [3];

    nfa_regex_prefix_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    nfa_regex_prefix_matcher_chk CHK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (i_valid),
        .i_word_ready (o_ready),
        .i_word       (i_data),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res        (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_words (live_words),
        .o_results    (results),
        .o_matches    (match_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side stalls in bursts
    always begin
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_ready <= 1'b1;
    end

    // unused fields carry random bits
    function automatic nfarx_pkg::t_in_word junk_word(logic [1:0] k);
        nfarx_pkg::t_in_word w;
        w.kind         = k;
        w.entry_index  = 5'($urandom);
        w.entry_char   = 8'($urandom);
        w.entry_is_eps = 1'($urandom);
        w.entry_next_a = 5'($urandom);
        w.entry_next_b = 5'($urandom);
        w.text_char    = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(nfarx_pkg::t_in_word w);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic load_entry(logic [4:0] idx, logic [7:0] ch, bit eps,
                              logic [4:0] na, logic [4:0] nb);
        nfarx_pkg::t_in_word w;
        w              = junk_word(nfarx_pkg::KIND_LOAD);
        w.entry_index  = idx;
        w.entry_char   = ch;
        w.entry_is_eps = eps;
        w.entry_next_a = na;
        w.entry_next_b = nb;
        send_word(w);
    endtask

    task automatic send_char(logic [7:0] c);
        nfarx_pkg::t_in_word w;
        w           = junk_word(nfarx_pkg::KIND_CHAR);
        w.text_char = c;
        send_word(w);
    endtask

    task automatic send_ctl(logic [1:0] k);
        send_word(junk_word(k));
    endtask

    // drop valid, wait for every expected result, then let a word with no result finish
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_start_state(logic [4:0] s);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [4:0] pick_member();
        return members[$urandom_range(0, n_members - 1)];
    endfunction

    // successors stay inside the member set so walks return to the start often
    task automatic load_member(logic [4:0] idx);
        bit eps;
        eps = ($urandom_range(0, 99) < 35);
        load_entry(idx, eps ? 8'($urandom) : alphabet[$urandom_range(0, 2)], eps,
                   pick_member(), pick_member());
    endtask

    task automatic program_table(logic [4:0] s);
        logic [4:0] cand;
        bit dup;
        int k;
        members[0] = s;
        n_members  = 1;
        k = $urandom_range(2, MAX_MEMBERS);
        while (n_members < k) begin
            cand = 5'($urandom);
            dup  = 1'b0;
            for (int j = 0; j < n_members; j++)
                if (members[j] == cand)
                    dup = 1'b1;
            if (!dup) begin
                members[n_members] = cand;
                n_members++;
            end
        end
        foreach (alphabet[j])
            alphabet[j] = 8'($urandom);
        for (int j = 0; j < n_members; j++)
            load_member(members[j]);
    endtask

    task automatic run_text();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 16);
        send_ctl(nfarx_pkg::KIND_START);
        repeat (len) begin
            if ($urandom_range(0, 7) == 0)
                send_char(8'($urandom));
            else
                send_char(alphabet[$urandom_range(0, 2)]);
        end
        send_ctl(nfarx_pkg::KIND_END);
        texts_sent++;
    endtask

    task automatic random_episode();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            send_word(junk_word(2'($urandom_range(2, 3))));
        else if (roll == 1)
            send_ctl(nfarx_pkg::KIND_START);
        else if (roll == 2)
            load_member(pick_member());
        else
            run_text();
    endtask

    initial begin
        int base;
        int goal;
        logic [4:0] s;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        set_start_state(5'd0);
        // every entry written once so no text ever reads an unwritten state
        for (int i = 0; i < N_STATES; i++) begin
            if (i > 5 && i < 31)
                load_entry(5'(i), 8'(i * 7), 1'b0, 5'(i), 5'(i));
        end
        load_entry(5'd0, 8'h61, 1'b0, 5'd1, 5'd1);
        load_entry(5'd1, 8'h00, 1'b1, 5'd2, 5'd3);
        load_entry(5'd2, 8'h00, 1'b0, 5'd0, 5'd0);
        load_entry(5'd3, 8'hFF, 1'b0, 5'd4, 5'd4);
        load_entry(5'd4, 8'h00, 1'b1, 5'd5, 5'd5);
        load_entry(5'd5, 8'hFF, 1'b1, 5'd4, 5'd31);
        load_entry(5'd31, 8'hFF, 1'b0, 5'd0, 5'd0);

        // match through a char state, then a word ignored after the decision
        send_ctl(nfarx_pkg::KIND_START);
        send_char(8'h61);
        send_char(8'h00);
        send_ctl(nfarx_pkg::KIND_END);
        // match after an epsilon cycle
        send_ctl(nfarx_pkg::KIND_START);
        send_char(8'h61);
        send_char(8'hFF);
        send_char(8'hFF);
        // empty active set, then no match at end of text
        send_ctl(nfarx_pkg::KIND_START);
        send_char(8'h62);
        send_ctl(nfarx_pkg::KIND_END);
        // empty text
        send_ctl(nfarx_pkg::KIND_START);
        send_ctl(nfarx_pkg::KIND_END);
        // empty prefix accepted on start
        load_entry(5'd0, 8'h00, 1'b1, 5'd1, 5'd0);
        send_ctl(nfarx_pkg::KIND_START);
        send_char(8'h61);
        send_ctl(nfarx_pkg::KIND_END);
        texts_sent += 5;

        base = words_sent;
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0)
                s = 5'd31;
            else if (p == N_PHASES / 2)
                s = 5'd0;
            else
                s = 5'($urandom);
            set_start_state(s);
            program_table(s);
            if (p >= N_PHASES - 2)
                idle_on = 1'b0;
            goal = base + (p + 1) * WORD_TARGET / N_PHASES;
            while (words_sent < goal)
                random_episode();
        end

        drain();
        $display("covered %0d words sent, %0d that moved the matcher, %0d texts, %0d start settings",
                 words_sent, live_words, texts_sent, cfg_writes);
        $display("%0d results compared, %0d of them matches", results, match_count);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- nfa_regex_prefix_matcher.f -----
rtl/nfarx_pkg.sv
rtl/nfarx_cell.sv
rtl/nfa_regex_prefix_matcher.sv
tb/nfa_regex_prefix_matcher_chk.sv
tb/nfa_regex_prefix_matcher_tb.sv
